[hdl/spf_pkg.sv]
// Shared types and constants for the SLIP packet framer.
package spf_pkg;

    // Largest payload length; longer requests saturate to this
    localparam logic [7:0] MAX_DATA = 8'd63;

    // SLIP special bytes
    localparam logic [7:0] CODE_END     = 8'hC0;
    localparam logic [7:0] CODE_ESC     = 8'hDB;
    localparam logic [7:0] CODE_ESC_END = 8'hDC;
    localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

    // Header byte 2 is this base plus the payload length
    localparam logic [7:0] LEN_BASE = 8'd16;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified command for the back end
    typedef struct packed {
        logic        is_data;  // 0: packet header, 1: payload byte
        logic        close;    // trailer and closing END follow
        logic [15:0] id;       // packet id stamped on every word
        logic [15:0] bitcnt;   // frame check value if close is set
        logic [15:0] word;     // flags and fragment offset
        logic [5:0]  len;      // saturated payload length
        logic [7:0]  proto;
        logic [7:0]  cksum;
        logic [15:0] dest;
        logic [7:0]  byte_val; // command byte or payload byte
    } t_cmd;

endpackage

[hdl/spf_front.sv]
// Front end: accepts input words, keeps packet state and builds back-end commands.
module spf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_func,
    input  logic [7:0]        i_protocol,
    input  logic [15:0]       i_dest_addr,
    input  logic [2:0]        i_flags,
    input  logic [12:0]       i_frag_offset,
    input  logic [7:0]        i_command,
    input  logic [5:0]        i_data_len,
    input  logic [7:0]        i_data_byte,
    output logic              o_push,
    output spf_pkg::t_cmd     o_cmd
);

    logic [15:0] r_id_counter, n_id_counter;
    logic [15:0] r_bit_count,  n_bit_count;
    logic [5:0]  r_bytes_due,  n_bytes_due;
    logic        r_in_frame,   n_in_frame;
    logic [15:0] r_current_id, n_current_id;

    logic [5:0]  len;
    logic [15:0] word;
    logic [7:0]  hsum;
    logic [3:0]  ones;

    // Saturate the requested length
    assign len = ({2'b00, i_data_len} > spf_pkg::MAX_DATA) ? spf_pkg::MAX_DATA[5:0]
                                                            : i_data_len;
    assign word = {i_flags, i_frag_offset};

    // Header checksum over bytes 0..6 (byte 7 counts as zero)
    assign hsum = word[15:8] + word[7:0] + (spf_pkg::LEN_BASE + {2'b00, len})
                + r_id_counter[15:8] + r_id_counter[7:0] + i_protocol;

    // One bits in the payload byte
    always_comb begin
        ones = '0;
        for (int k = 0; k < 8; k++) begin
            ones = ones + {3'b000, i_data_byte[k]};
        end
    end

    // Classify the word and work out the next packet state
    always_comb begin
        n_id_counter = r_id_counter;
        n_bit_count  = r_bit_count;
        n_bytes_due  = r_bytes_due;
        n_in_frame   = r_in_frame;
        n_current_id = r_current_id;
        o_push       = 1'b0;

        o_cmd          = '0;
        o_cmd.word     = word;
        o_cmd.len      = len;
        o_cmd.proto    = i_protocol;
        o_cmd.cksum    = ~hsum;
        o_cmd.dest     = i_dest_addr;

        if (i_accept) begin
            if (!i_func) begin
                n_current_id   = r_id_counter;
                n_id_counter   = r_id_counter + 16'd1;
                n_bit_count    = '0;
                n_bytes_due    = len;
                n_in_frame     = (len != '0);
                o_push         = 1'b1;
                o_cmd.is_data  = 1'b0;
                o_cmd.close    = (len == '0);
                o_cmd.id       = r_id_counter;
                o_cmd.bitcnt   = '0;
                o_cmd.byte_val = i_command;
            end else if (r_in_frame) begin
                n_bit_count    = r_bit_count + {12'd0, ones};
                n_bytes_due    = (r_bytes_due != '0) ? r_bytes_due - 6'd1 : r_bytes_due;
                o_push         = 1'b1;
                o_cmd.is_data  = 1'b1;
                o_cmd.close    = (n_bytes_due == '0);
                o_cmd.id       = r_current_id;
                o_cmd.bitcnt   = n_bit_count;
                o_cmd.byte_val = i_data_byte;
                if (n_bytes_due == '0) begin
                    n_in_frame = 1'b0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_counter <= '0;
            r_bit_count  <= '0;
            r_bytes_due  <= '0;
            r_in_frame   <= 1'b0;
            r_current_id <= '0;
        end else begin
            r_id_counter <= n_id_counter;
            r_bit_count  <= n_bit_count;
            r_bytes_due  <= n_bytes_due;
            r_in_frame   <= n_in_frame;
            r_current_id <= n_current_id;
        end
    end

endmodule

[hdl/spf_queue.sv]
// Short command queue between the front and back ends.
module spf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spf_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output spf_pkg::t_cmd     o_cmd
);

    spf_pkg::t_cmd                r_mem [spf_pkg::Q_DEPTH];
    logic [spf_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [spf_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [spf_pkg::Q_AW:0]       r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (spf_pkg::Q_AW + 1)'(spf_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/spf_back.sv]
// Back end: walks each command byte by byte, SLIP-escapes and drives the output word.
module spf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_q_empty,
    input  spf_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_tx_byte,
    output logic              o_frame_end,
    output logic [15:0]       o_packet_id
);

    // Byte positions within a command
    localparam logic [4:0] POS_OPEN  = 5'd0;
    localparam logic [4:0] POS_CMD   = 5'd13;
    localparam logic [4:0] POS_LEN   = 5'd14;
    localparam logic [4:0] POS_DATA  = 5'd15;
    localparam logic [4:0] POS_CHKHI = 5'd16;
    localparam logic [4:0] POS_CHKLO = 5'd17;
    localparam logic [4:0] POS_CLOSE = 5'd18;

    logic [15:0]   r_own_addr;
    spf_pkg::t_cmd r_cur;
    logic          r_busy;
    logic [4:0]    r_pos;
    logic          r_esc;
    logic [7:0]    r_esc_byte;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_end;
    logic [15:0]   r_out_id;

    logic [7:0]    hdr [16];
    logic [3:0]    hidx;
    logic [7:0]    raw;
    logic          need_esc;
    logic          advance;
    logic          last_pos;
    logic [4:0]    next_pos;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= '0;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_wdata;
        end
    end

    // Header bytes of the current command
    always_comb begin
        hdr[0]  = r_cur.word[15:8];
        hdr[1]  = r_cur.word[7:0];
        hdr[2]  = spf_pkg::LEN_BASE + {2'b00, r_cur.len};
        hdr[3]  = 8'h00;
        hdr[4]  = r_cur.id[15:8];
        hdr[5]  = r_cur.id[7:0];
        hdr[6]  = r_cur.proto;
        hdr[7]  = r_cur.cksum;
        hdr[8]  = r_own_addr[15:8];
        hdr[9]  = r_own_addr[7:0];
        hdr[10] = r_cur.dest[15:8];
        hdr[11] = r_cur.dest[7:0];
        hdr[12] = 8'h00;
        hdr[13] = 8'h00;
        hdr[14] = 8'h00;
        hdr[15] = 8'h00;
    end

    assign hidx = r_pos[3:0] - 4'd1;

    // Unescaped byte at the current position
    always_comb begin
        case (r_pos)
            POS_OPEN:  raw = spf_pkg::CODE_END;
            POS_CMD:   raw = r_cur.byte_val;
            POS_LEN:   raw = {2'b00, r_cur.len};
            POS_DATA:  raw = r_cur.byte_val;
            POS_CHKHI: raw = r_cur.bitcnt[15:8];
            POS_CHKLO: raw = r_cur.bitcnt[7:0];
            POS_CLOSE: raw = spf_pkg::CODE_END;
            default:   raw = hdr[hidx];
        endcase
    end

    assign need_esc = (r_pos != POS_OPEN) && (r_pos != POS_CLOSE)
                   && ((raw == spf_pkg::CODE_END) || (raw == spf_pkg::CODE_ESC));

    // Sequencing after the current position
    always_comb begin
        last_pos = 1'b0;
        next_pos = r_pos + 5'd1;
        if ((r_pos == POS_LEN) || (r_pos == POS_DATA)) begin
            next_pos = POS_CHKHI;
            last_pos = !r_cur.close;
        end else if (r_pos == POS_CLOSE) begin
            last_pos = 1'b1;
        end
    end

    assign advance = r_busy && (!r_out_valid || i_pop);
    assign o_q_pop = !r_busy && !i_q_empty;

    // Command walker and output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= POS_OPEN;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid && !advance) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_cur  <= i_q_cmd;
                r_busy <= 1'b1;
                r_esc  <= 1'b0;
                r_pos  <= i_q_cmd.is_data ? POS_DATA : POS_OPEN;
            end else if (advance) begin
                r_out_valid <= 1'b1;
                r_out_id    <= r_cur.id;
                r_out_end   <= 1'b0;
                if (r_esc) begin
                    r_out_byte <= r_esc_byte;
                    r_esc      <= 1'b0;
                    r_pos      <= next_pos;
                    r_busy     <= !last_pos;
                end else if (need_esc) begin
                    r_out_byte <= spf_pkg::CODE_ESC;
                    r_esc      <= 1'b1;
                    r_esc_byte <= (raw == spf_pkg::CODE_END) ? spf_pkg::CODE_ESC_END
                                                             : spf_pkg::CODE_ESC_ESC;
                end else begin
                    r_out_byte <= raw;
                    r_out_end  <= (r_pos == POS_CLOSE);
                    r_pos      <= next_pos;
                    r_busy     <= !last_pos;
                end
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_frame_end = r_out_end;
    assign o_packet_id = r_out_id;

endmodule

[hdl/slip_packet_framer_unit.sv]
// SLIP packet framer: header and payload words in, escaped serial bytes out.
// A pushed word passes through the command queue and the back end's command register
// before its first byte is registered on the output. Output runs at one byte per cycle
// while the receiver pops; each command is loaded from the queue before it is walked.
// Reset (synchronous, active low) empties the command queue and output register and
// clears the id counter, packet state and own address.
module slip_packet_framer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic        i_func,
    input  logic [7:0]  i_protocol,
    input  logic [15:0] i_dest_addr,
    input  logic [2:0]  i_flags,
    input  logic [12:0] i_frag_offset,
    input  logic [7:0]  i_command,
    input  logic [5:0]  i_data_len,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end,
    output logic [15:0] o_packet_id
);

    logic          accept;
    logic          f_push;
    spf_pkg::t_cmd f_cmd;
    logic          q_empty;
    logic          q_pop;
    spf_pkg::t_cmd q_cmd;

    assign accept = push && !full;

    // Front end: classify input words
    spf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_func        (i_func),
        .i_protocol    (i_protocol),
        .i_dest_addr   (i_dest_addr),
        .i_flags       (i_flags),
        .i_frag_offset (i_frag_offset),
        .i_command     (i_command),
        .i_data_len    (i_data_len),
        .i_data_byte   (i_data_byte),
        .o_push        (f_push),
        .o_cmd         (f_cmd)
    );

    // Command queue
    spf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Back end: byte walker and SLIP escaping
    spf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end),
        .o_packet_id (o_packet_id)
    );

endmodule

[bench/tb_slip_packet_framer_unit.sv]
// Self-checking testbench for the SLIP packet framer: queue-driven stimulus, byte-level checks.
`timescale 1ns / 1ps

module tb_slip_packet_framer_unit;

    // Input word kinds
    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_DATA   = 1'b1;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 40;
    localparam int RX_HOLD_CYCLES = 400;

    // One input word as offered on the push side
    typedef struct {
        logic        func;
        logic [7:0]  protocol;
        logic [15:0] dest_addr;
        logic [2:0]  flags;
        logic [12:0] frag_offset;
        logic [7:0]  command;
        logic [5:0]  data_len;
        logic [7:0]  data_byte;
    } t_spf_word;

    // One byte on the serial side
    typedef struct {
        logic [7:0]  tx_byte;
        logic        frame_end;
        logic [15:0] packet_id;
    } t_line_byte;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [15:0] i_cfg_wdata   = '0;
    logic        push          = 1'b0;
    logic        full;
    logic        i_func        = 1'b0;
    logic [7:0]  i_protocol    = '0;
    logic [15:0] i_dest_addr   = '0;
    logic [2:0]  i_flags       = '0;
    logic [12:0] i_frag_offset = '0;
    logic [7:0]  i_command     = '0;
    logic [5:0]  i_data_len    = '0;
    logic [7:0]  i_data_byte   = '0;
    logic        empty;
    logic        pop           = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_frame_end;
    logic [15:0] o_packet_id;

    // Stimulus and expectation stores
    t_spf_word  word_q[$];
    t_line_byte line_q[$];
    t_spf_word  drv_word;

    // Framer state as predicted
    logic [15:0] m_own    = '0;
    logic [15:0] m_id_ctr = '0;
    logic [15:0] m_ones   = '0;
    logic [5:0]  m_due    = '0;
    logic        m_open   = 1'b0;
    logic [15:0] m_cur_id = '0;

    // Run control and bookkeeping
    int   tx_idle_pct = 36;
    int   rx_idle_pct = 61;
    bit   stall_go    = 1'b0;
    logic rx_stall    = 1'b0;
    int   err_cnt     = 0;
    int   words_in    = 0;
    int   pkt_cnt     = 0;
    int   bytes_seen  = 0;
    int   full_stalls = 0;
    int   cycle_cnt   = 0;

    slip_packet_framer_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_protocol   (i_protocol),
        .i_dest_addr  (i_dest_addr),
        .i_flags      (i_flags),
        .i_frag_offset(i_frag_offset),
        .i_command    (i_command),
        .i_data_len   (i_data_len),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_tx_byte    (o_tx_byte),
        .o_frame_end  (o_frame_end),
        .o_packet_id  (o_packet_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor: turns each accepted word into the bytes it must send
    // ---------------------------------------------------------------
    function automatic void emit_raw(logic [7:0] b, logic fe);
        t_line_byte e;
        e.tx_byte   = b;
        e.frame_end = fe;
        e.packet_id = m_cur_id;
        line_q.push_back(e);
    endfunction

    function automatic void emit_escaped(logic [7:0] b);
        if (b == spf_pkg::CODE_END) begin
            emit_raw(spf_pkg::CODE_ESC, 1'b0);
            emit_raw(spf_pkg::CODE_ESC_END, 1'b0);
        end else if (b == spf_pkg::CODE_ESC) begin
            emit_raw(spf_pkg::CODE_ESC, 1'b0);
            emit_raw(spf_pkg::CODE_ESC_ESC, 1'b0);
        end else begin
            emit_raw(b, 1'b0);
        end
    endfunction

    // frame check high byte first, then the closing END
    function automatic void emit_trailer();
        emit_escaped(m_ones[15:8]);
        emit_escaped(m_ones[7:0]);
        emit_raw(spf_pkg::CODE_END, 1'b1);
        m_open = 1'b0;
    endfunction

    function automatic void predict_word(t_spf_word w);
        logic [7:0]  hdr [12];
        logic [15:0] fw;
        logic [7:0]  sum;
        logic [5:0]  len;
        int          i;
        if (w.func == FUNC_HEADER) begin
            len = ({2'b00, w.data_len} > spf_pkg::MAX_DATA) ? spf_pkg::MAX_DATA[5:0]
                                                            : w.data_len;
            m_cur_id = m_id_ctr;
            m_id_ctr = m_id_ctr + 16'd1;
            pkt_cnt++;
            fw = {w.flags, w.frag_offset};
            hdr[0]  = fw[15:8];
            hdr[1]  = fw[7:0];
            hdr[2]  = spf_pkg::LEN_BASE + {2'b00, len};
            hdr[3]  = 8'h00;
            hdr[4]  = m_cur_id[15:8];
            hdr[5]  = m_cur_id[7:0];
            hdr[6]  = w.protocol;
            hdr[7]  = 8'h00;
            hdr[8]  = m_own[15:8];
            hdr[9]  = m_own[7:0];
            hdr[10] = w.dest_addr[15:8];
            hdr[11] = w.dest_addr[7:0];
            sum = 8'h00;
            for (i = 0; i < 8; i++) sum = sum + hdr[i];
            hdr[7] = ~sum;
            // an open packet is simply abandoned here
            emit_raw(spf_pkg::CODE_END, 1'b0);
            for (i = 0; i < 12; i++) emit_escaped(hdr[i]);
            emit_escaped(w.command);
            emit_escaped({2'b00, len});
            m_ones = '0;
            m_due  = len;
            m_open = 1'b1;
            if (m_due == 6'd0) emit_trailer();
        end else if (m_open) begin
            emit_escaped(w.data_byte);
            for (i = 0; i < 8; i++) m_ones = m_ones + {15'd0, w.data_byte[i]};
            if (m_due != 6'd0) m_due = m_due - 6'd1;
            if (m_due == 6'd0) emit_trailer();
        end
        // data word with no packet open: dropped, nothing sent
    endfunction

    // ---------------------------------------------------------------
    // Word builders
    // ---------------------------------------------------------------
    function automatic t_spf_word make_header(logic [7:0] proto, logic [15:0] dest,
                                              logic [2:0] flg, logic [12:0] off,
                                              logic [7:0] cmd, logic [5:0] len);
        t_spf_word w;
        w.func        = FUNC_HEADER;
        w.protocol    = proto;
        w.dest_addr   = dest;
        w.flags       = flg;
        w.frag_offset = off;
        w.command     = cmd;
        w.data_len    = len;
        w.data_byte   = 8'($urandom_range(255));
        return w;
    endfunction

    function automatic t_spf_word make_data(logic [7:0] b);
        t_spf_word w;
        w.func        = FUNC_DATA;
        w.protocol    = 8'($urandom_range(255));
        w.dest_addr   = 16'($urandom_range(65535));
        w.flags       = 3'($urandom_range(7));
        w.frag_offset = 13'($urandom_range(8191));
        w.command     = 8'($urandom_range(255));
        w.data_len    = 6'($urandom_range(63));
        w.data_byte   = b;
        return w;
    endfunction

    // payload bytes lean toward the two SLIP specials
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(7);
        if (r == 0) return spf_pkg::CODE_END;
        if (r == 1) return spf_pkg::CODE_ESC;
        return 8'($urandom_range(255));
    endfunction

    // Mostly complete packets; some cut short, some stray data words
    task automatic queue_traffic(int n_words);
        int queued;
        int r;
        int len;
        int sent;
        int k;
        queued = 0;
        while (queued < n_words) begin
            r = $urandom_range(99);
            if (r < 8) begin
                word_q.push_back(make_data(rand_byte()));
                queued += 1;
            end else begin
                len  = ($urandom_range(99) < 6) ? 63 : $urandom_range(6);
                sent = (r < 16) ? $urandom_range(len) : len;
                word_q.push_back(make_header(rand_byte(), 16'($urandom_range(65535)),
                                             3'($urandom_range(7)),
                                             13'($urandom_range(8191)),
                                             rand_byte(), len[5:0]));
                for (k = 0; k < sent; k++) word_q.push_back(make_data(rand_byte()));
                queued += 1 + sent;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued words, predicts on acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        bit load;
        load = 1'b0;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_word(drv_word);
                words_in++;
            end
            if (push && full) full_stalls++;
            // slot free: maybe present the next word
            if (!push || !full) begin
                if (word_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    drv_word = word_q.pop_front();
                    load = 1'b1;
                end
                push <= load;
            end
            if (load) begin
                i_func        <= drv_word.func;
                i_protocol    <= drv_word.protocol;
                i_dest_addr   <= drv_word.dest_addr;
                i_flags       <= drv_word.flags;
                i_frag_offset <= drv_word.frag_offset;
                i_command     <= drv_word.command;
                i_data_len    <= drv_word.data_len;
                i_data_byte   <= drv_word.data_byte;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each popped byte against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_line_byte e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                bytes_seen++;
                if (line_q.size() == 0) begin
                    $error("unexpected byte %h (frame_end %b, id %h)",
                           o_tx_byte, o_frame_end, o_packet_id);
                    err_cnt++;
                end else begin
                    e = line_q.pop_front();
                    if (o_tx_byte !== e.tx_byte) begin
                        $error("tx_byte: expected %h, got %h", e.tx_byte, o_tx_byte);
                        err_cnt++;
                    end
                    if (o_frame_end !== e.frame_end) begin
                        $error("frame_end: expected %b, got %b", e.frame_end, o_frame_end);
                        err_cnt++;
                    end
                    if (o_packet_id !== e.packet_id) begin
                        $error("packet_id: expected %h, got %h", e.packet_id, o_packet_id);
                        err_cnt++;
                    end
                end
            end
            pop <= !rx_stall && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted here on its own
    initial begin
        wait (stall_go);
        @(posedge i_clk);
        rx_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_stall <= 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cycle_cnt, line_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencing
    // ---------------------------------------------------------------
    task automatic write_own_address(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        m_own = v;
    endtask

    // all words taken, all bytes seen, then let dropped words drain
    task automatic wait_idle();
        do @(negedge i_clk); while (word_q.size() != 0 || push || line_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: address bytes that need escaping
        write_own_address(16'hC0DB);
        @(negedge i_clk);
        word_q.push_back(make_data(8'hFF));                   // stray data, dropped
        word_q.push_back(make_header(8'hFF, 16'hFFFF, 3'h7, 13'h1FFF, 8'hFF, 6'd0));
        word_q.push_back(make_header(8'h00, 16'h0000, 3'h0, 13'h0000, 8'h00, 6'd2));
        word_q.push_back(make_data(spf_pkg::CODE_END));
        word_q.push_back(make_data(spf_pkg::CODE_ESC));
        word_q.push_back(make_header(spf_pkg::CODE_END, 16'hC0DB, 3'h5, 13'h1555,
                                     spf_pkg::CODE_ESC, 6'd3));
        word_q.push_back(make_data(8'h00));
        word_q.push_back(make_data(8'hFF));
        // new header while a packet is still open
        word_q.push_back(make_header(spf_pkg::CODE_ESC, 16'hDBC0, 3'h2, 13'h0AAA,
                                     spf_pkg::CODE_END, 6'd1));
        word_q.push_back(make_data(spf_pkg::CODE_END));
        word_q.push_back(make_data(8'h00));                   // after close, dropped
        word_q.push_back(make_header(8'h5A, 16'h1234, 3'h1, 13'h1000, 8'h80, 6'd1));
        word_q.push_back(make_data(8'h7F));
        wait_idle();

        // random, sender idles less than receiver
        write_own_address(16'hFFFF);
        @(negedge i_clk);
        queue_traffic(85);
        wait_idle();

        // random, roles swapped
        write_own_address(16'h0000);
        @(negedge i_clk);
        tx_idle_pct = 61;
        rx_idle_pct = 36;
        queue_traffic(85);
        wait_idle();

        // random, no idling
        write_own_address(16'($urandom_range(65535)));
        @(negedge i_clk);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_traffic(85);
        wait_idle();

        // back-pressure: receiver holds off while words keep coming
        @(negedge i_clk);
        stall_go = 1'b1;
        queue_traffic(60);
        wait_idle();

        $display("Covered %0d words over %0d packets, %0d serial bytes checked.",
                 words_in, pkt_cnt, bytes_seen);
        $display("Input held off by full on %0d cycles; %0d mismatches.", full_stalls, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[slip_packet_framer_unit.f]
hdl/spf_pkg.sv
hdl/spf_front.sv
hdl/spf_queue.sv
hdl/spf_back.sv
hdl/slip_packet_framer_unit.sv
bench/tb_slip_packet_framer_unit.sv
